>>> hw/rtl/crps_pkg.sv
// Shared types, constants and the spline weight table for the path smoother.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package crps_pkg;

  // number of trailing zero bits of a positive constant
  function automatic int crps_tz(input int v);
    int r;
    r = 0;
    for (int i = 0; i < 31; i++) begin
      if (r == i && v[i] == 1'b0) r = i + 1;
    end
    return r;
  endfunction

  localparam int COORD_W  = 24;
  localparam int STEPS    = 20;
  localparam int DEN      = 2 * STEPS * STEPS * STEPS;
  localparam int DEN_W    = $clog2(DEN + 1);
  localparam int W_W      = DEN_W + 1;
  localparam int PROD_W   = COORD_W + W_W;
  localparam int NUM_W    = PROD_W + 2;
  localparam int REM_W    = COORD_W + DEN_W;
  localparam int S_W      = $clog2(STEPS + 1);
  localparam int DEN_TZ   = crps_tz(DEN);
  localparam int ODD_DEN  = DEN >> DEN_TZ;
  localparam int DVD_W    = REM_W - DEN_TZ;
  localparam int RECIP_SH = DVD_W + $clog2(ODD_DEN);
  localparam int RECIP_W  = DVD_W + 1;
  localparam int QDEPTH   = 2;
  localparam int QP_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QC_W     = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [W_W-1:0]     wt_t;
  typedef wt_t [3:0]                 wvec_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic [DVD_W-1:0]          dvd_t;
  typedef logic [RECIP_W-1:0]        recip_t;
  typedef logic [DVD_W+RECIP_W-1:0]  dprod_t;
  typedef logic [COORD_W-1:0]        quo_t;

  localparam coord_t COORD_MAX = coord_t'((1 << (COORD_W - 1)) - 1);
  localparam coord_t COORD_MIN = coord_t'(-(1 << (COORD_W - 1)));
  localparam num_t   HALF_DEN  = num_t'(DEN / 2);
  localparam num_t   SAT_LIM   = num_t'(DEN) <<< (COORD_W - 1);
  localparam num_t   NEG_LIM   = -SAT_LIM;
  // rounded-up reciprocal of the odd part of DEN, scaled by 2^RECIP_SH
  localparam recip_t RECIP     = recip_t'(((longint'(1) << RECIP_SH) + longint'(ODD_DEN) - 1)
                                          / longint'(ODD_DEN));

  typedef enum logic {
    CMD_PASS,
    CMD_SEG
  } cmd_kind_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   final_point;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    logic   path_end;
  } out_item_t;

  // One unit of work for the back end: a single point or a whole segment.
  typedef struct packed {
    cmd_kind_t    kind;
    logic         last;
    coord_t [3:0] px;
    coord_t [3:0] py;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic last;
    num_t ax;
    num_t ay;
  } div_in_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic sat_hi_x;
    logic sat_lo_x;
    logic sat_hi_y;
    logic sat_lo_y;
    quo_t q_x;
    quo_t q_y;
  } div_out_t;

  // Catmull-Rom weights over the denominator DEN; step zero gives (0, DEN, 0, 0).
  function automatic wvec_t crps_weights(input logic [S_W-1:0] s);
    int    n;
    int    k;
    wvec_t r;
    n = STEPS;
    k = int'(s);
    r[0] = wt_t'(-k * n * n + 2 * k * k * n - k * k * k);
    r[1] = wt_t'(2 * n * n * n - 5 * k * k * n + 3 * k * k * k);
    r[2] = wt_t'(k * n * n + 4 * k * k * n - 3 * k * k * k);
    r[3] = wt_t'(-k * k * n + k * k * k);
    return r;
  endfunction

endpackage

>>> hw/rtl/catmull_rom_path_smoother.sv
// Uniform Catmull-Rom path smoother, top level.
// Instantiates crps_front, crps_queue and crps_back; types from crps_pkg.
//
// Input channel (in_valid / in_stall / in_data): one control point per item,
// Q15.8 x and y, final_point set on the last point of a path. Output channel
// (out_valid / out_stall / out_data): smoothed samples, path_end set on the
// last sample of a path. An item moves when valid is high and stall is low.
// The first point comes back as is; from the third point on, each point
// gives STEPS (20) samples of the segment between the two points before it,
// and a final point adds the closing segment (2*STEPS samples in all).
// The back end produces one sample per cycle unless the output stalls; the
// front end and a two-entry command queue run ahead of it. An accepted point's
// first sample passes through the queue, the sequencer, the weight, multiply
// and sum stages, a two-stage reciprocal divider and the result register.
// Reset (rst_n low, synchronous) empties the queue and pipeline and starts a
// new path. While out_stall is high and a sample waits at the output, the
// whole sample pipeline holds; the input keeps taking points until the queue
// fills.
`timescale 1ns / 1ps

module catmull_rom_path_smoother (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output crps_pkg::out_item_t out_data
);
  import crps_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_push_cmd, q_head;

  crps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .push    (q_push),
    .push_cmd(q_push_cmd),
    .q_full  (q_full)
  );

  crps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .head_valid(q_valid)
  );

  crps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command queue read while empty");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

>>> hw/rtl/crps_front.sv
// Front end: takes control points, keeps the three-point window and turns each
// point into pass or segment commands for the queue. Depends on crps_pkg.
`timescale 1ns / 1ps

module crps_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  crps_pkg::in_item_t in_data,
  output logic            push,
  output crps_pkg::cmd_t  push_cmd,
  input  logic            q_full
);
  import crps_pkg::*;

  coord_t     wx_r [3];
  coord_t     wy_r [3];
  coord_t     wx_nxt [3];
  coord_t     wy_nxt [3];
  logic [1:0] ps_r, ps_nxt;
  logic       pend_r, pend_nxt;
  cmd_t       pend_cmd_r, pend_cmd_nxt;

  logic   acc;
  logic   fin;
  logic   gen;
  coord_t x, y;
  cmd_t   pass_cmd, seg_cmd, close_cmd;

  assign x   = in_data.point_x;
  assign y   = in_data.point_y;
  assign fin = in_data.final_point;

  assign in_stall = pend_r || q_full;
  assign acc      = in_valid && !in_stall;
  assign gen      = acc && (ps_r != 2'd1 || fin);

  always_comb begin
    pass_cmd       = '0;
    pass_cmd.kind  = CMD_PASS;
    pass_cmd.last  = fin;
    pass_cmd.px[1] = x;
    pass_cmd.py[1] = y;

    seg_cmd       = '0;
    seg_cmd.kind  = CMD_SEG;
    seg_cmd.last  = 1'b0;
    seg_cmd.px[0] = wx_r[0];
    seg_cmd.px[1] = wx_r[1];
    seg_cmd.px[2] = wx_r[2];
    seg_cmd.px[3] = x;
    seg_cmd.py[0] = wy_r[0];
    seg_cmd.py[1] = wy_r[1];
    seg_cmd.py[2] = wy_r[2];
    seg_cmd.py[3] = y;

    // closing segment: last point doubles as its own next neighbor
    close_cmd       = '0;
    close_cmd.kind  = CMD_SEG;
    close_cmd.last  = 1'b1;
    close_cmd.px[0] = wx_r[1];
    close_cmd.px[1] = wx_r[2];
    close_cmd.px[2] = x;
    close_cmd.px[3] = x;
    close_cmd.py[0] = wy_r[1];
    close_cmd.py[1] = wy_r[2];
    close_cmd.py[2] = y;
    close_cmd.py[3] = y;
  end

  assign push     = pend_r ? !q_full : gen;
  assign push_cmd = pend_r ? pend_cmd_r : ((ps_r >= 2'd2) ? seg_cmd : pass_cmd);

  always_comb begin
    ps_nxt       = ps_r;
    pend_nxt     = pend_r;
    pend_cmd_nxt = pend_cmd_r;
    for (int i = 0; i < 3; i++) begin
      wx_nxt[i] = wx_r[i];
      wy_nxt[i] = wy_r[i];
    end
    if (pend_r && !q_full) begin
      pend_nxt = 1'b0;
    end
    if (acc) begin
      if (fin) begin
        ps_nxt = 2'd0;
        if (ps_r >= 2'd2) begin
          pend_nxt     = 1'b1;
          pend_cmd_nxt = close_cmd;
        end
      end else if (ps_r == 2'd0) begin
        for (int i = 0; i < 3; i++) begin
          wx_nxt[i] = x;
          wy_nxt[i] = y;
        end
        ps_nxt = 2'd1;
      end else begin
        wx_nxt[0] = wx_r[1];
        wx_nxt[1] = wx_r[2];
        wx_nxt[2] = x;
        wy_nxt[0] = wy_r[1];
        wy_nxt[1] = wy_r[2];
        wy_nxt[2] = y;
        ps_nxt    = (ps_r == 2'd3) ? 2'd3 : ps_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r   <= 2'd0;
      pend_r <= 1'b0;
    end else begin
      ps_r   <= ps_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_cmd_r <= pend_cmd_nxt;
    for (int i = 0; i < 3; i++) begin
      wx_r[i] <= wx_nxt[i];
      wy_r[i] <= wy_nxt[i];
    end
  end

endmodule

>>> hw/rtl/crps_queue.sv
// Short command queue between the front and back ends.
// Depends on crps_pkg for the command type and depth.
`timescale 1ns / 1ps

module crps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  crps_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output crps_pkg::cmd_t head,
  output logic           head_valid
);
  import crps_pkg::*;

  cmd_t            mem_r [QDEPTH];
  logic [QP_W-1:0] wp_r, wp_nxt;
  logic [QP_W-1:0] rp_r, rp_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QC_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QP_W'(QDEPTH - 1)) ? '0 : wp_r + QP_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == QP_W'(QDEPTH - 1)) ? '0 : rp_r + QP_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QC_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

>>> hw/rtl/crps_div.sv
// Rounding divide by the spline denominator: saturation check and offset, then
// a reciprocal multiply; two pipeline stages for both coordinates. Depends on crps_pkg.
`timescale 1ns / 1ps

module crps_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  crps_pkg::div_in_t  din,
  output crps_pkg::div_out_t dout
);
  import crps_pkg::*;

  logic [1:0] vld_r;
  logic [1:0] lst_r;
  logic [1:0] shx_r, slx_r, shy_r, sly_r;
  dvd_t       cx_r, cy_r;
  quo_t       qx_r, qy_r;

  num_t   bx, by;
  dprod_t mx, my;

  // offset into the unsigned range so the quotient lands in [0, 2^24)
  assign bx = din.ax + SAT_LIM;
  assign by = din.ay + SAT_LIM;

  // drop the power-of-two part of DEN first, then multiply by the rounded-up
  // reciprocal of the odd part; exact over the whole dividend range
  assign mx = dprod_t'(cx_r) * dprod_t'(RECIP);
  assign my = dprod_t'(cy_r) * dprod_t'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[0], din.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lst_r <= {lst_r[0], din.last};
      shx_r <= {shx_r[0], din.ax >= SAT_LIM};
      slx_r <= {slx_r[0], din.ax < NEG_LIM};
      shy_r <= {shy_r[0], din.ay >= SAT_LIM};
      sly_r <= {sly_r[0], din.ay < NEG_LIM};
      cx_r  <= bx[REM_W-1:DEN_TZ];
      cy_r  <= by[REM_W-1:DEN_TZ];
      qx_r  <= mx[RECIP_SH +: COORD_W];
      qy_r  <= my[RECIP_SH +: COORD_W];
    end
  end

  always_comb begin
    dout.valid    = vld_r[1];
    dout.last     = lst_r[1];
    dout.sat_hi_x = shx_r[1];
    dout.sat_lo_x = slx_r[1];
    dout.sat_hi_y = shy_r[1];
    dout.sat_lo_y = sly_r[1];
    dout.q_x      = qx_r;
    dout.q_y      = qy_r;
  end

endmodule

>>> hw/rtl/crps_back.sv
// Back end: steps through each command's samples, weights and sums the four
// points, divides and saturates, and holds the result register. Uses crps_pkg
// and crps_div.
`timescale 1ns / 1ps

module crps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  crps_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output crps_pkg::out_item_t out_data
);
  import crps_pkg::*;

  logic           busy_r, busy_nxt;
  cmd_t           cmd_r, cmd_nxt;
  logic [S_W-1:0] s_r, s_nxt;

  logic           v1_r, l1_r;
  wvec_t          w1_r;
  coord_t [3:0]   px1_r, py1_r;
  logic           v2_r, l2_r;
  prod_t          prx2_r [4];
  prod_t          pry2_r [4];
  logic           v3_r, l3_r;
  num_t           ax3_r, ay3_r;

  logic           out_valid_r;
  out_item_t      out_data_r;

  logic           adv;
  logic           last_smp;
  logic [S_W-1:0] s_end;
  div_in_t        dv_in;
  div_out_t       dv_out;
  out_item_t      res;

  // the whole pipeline moves unless a finished sample is stuck at the output
  assign adv      = !(out_valid_r && out_stall);
  assign s_end    = (cmd_r.kind == CMD_PASS) ? '0 : S_W'(STEPS);
  assign last_smp = (s_r == s_end);
  assign q_pop    = q_valid && adv && (!busy_r || last_smp);

  always_comb begin
    busy_nxt = busy_r;
    cmd_nxt  = cmd_r;
    s_nxt    = s_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      cmd_nxt  = q_head;
      s_nxt    = (q_head.kind == CMD_PASS) ? '0 : S_W'(1);
    end else if (busy_r && adv) begin
      if (last_smp) begin
        busy_nxt = 1'b0;
      end else begin
        s_nxt = s_r + S_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (adv) begin
        v1_r        <= busy_r;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        out_valid_r <= dv_out.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    s_r   <= s_nxt;
    if (adv) begin
      w1_r  <= crps_weights(s_r);
      px1_r <= cmd_r.px;
      py1_r <= cmd_r.py;
      l1_r  <= cmd_r.last && last_smp;
      for (int i = 0; i < 4; i++) begin
        prx2_r[i] <= $signed(w1_r[i]) * $signed(px1_r[i]);
        pry2_r[i] <= $signed(w1_r[i]) * $signed(py1_r[i]);
      end
      l2_r  <= l1_r;
      ax3_r <= num_t'(prx2_r[0]) + num_t'(prx2_r[1]) + num_t'(prx2_r[2])
             + num_t'(prx2_r[3]) + HALF_DEN;
      ay3_r <= num_t'(pry2_r[0]) + num_t'(pry2_r[1]) + num_t'(pry2_r[2])
             + num_t'(pry2_r[3]) + HALF_DEN;
      l3_r  <= l2_r;
      out_data_r <= res;
    end
  end

  always_comb begin
    dv_in.valid = v3_r;
    dv_in.last  = l3_r;
    dv_in.ax    = ax3_r;
    dv_in.ay    = ay3_r;
  end

  crps_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .din  (dv_in),
    .dout (dv_out)
  );

  // undo the offset by flipping the quotient's top bit, clamp out-of-range
  always_comb begin
    if (dv_out.sat_hi_x) begin
      res.out_x = COORD_MAX;
    end else if (dv_out.sat_lo_x) begin
      res.out_x = COORD_MIN;
    end else begin
      res.out_x = coord_t'({~dv_out.q_x[COORD_W-1], dv_out.q_x[COORD_W-2:0]});
    end
    if (dv_out.sat_hi_y) begin
      res.out_y = COORD_MAX;
    end else if (dv_out.sat_lo_y) begin
      res.out_y = COORD_MIN;
    end else begin
      res.out_y = coord_t'({~dv_out.q_y[COORD_W-1], dv_out.q_y[COORD_W-2:0]});
    end
    res.path_end = dv_out.last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
